FILE: hw/rtl/data_url_payload_decoder_top_assert.svh
// assertion helpers for the data url payload decoder
`ifndef DATA_URL_PAYLOAD_DECODER_TOP_ASSERT_SVH
`define DATA_URL_PAYLOAD_DECODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define DUP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DUP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dup_pkg.sv
`timescale 1ns / 1ps

package dup_pkg;

  // result slots one character can produce
  localparam int PktSlots = 3;
  // depth of the packet queue between front and back
  localparam int PktDepth = 4;
  localparam int PktPtrW  = $clog2(PktDepth);

  localparam logic [7:0] CharPct   = 8'h25;
  localparam logic [7:0] CharEq    = 8'h3D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;

  // one classified character: up to three result transactions
  typedef struct packed {
    logic [1:0]                cnt;
    logic                      no_byte;
    logic                      last;
    logic                      err;
    logic [PktSlots-1:0][7:0]  bytes;
  } pkt_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eop;
    logic       err;
  } res_t;

  // base64 alphabet lookup: {valid, six-bit value}
  function automatic logic [6:0] b64_lookup(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h47)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c + 8'h04)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  // hex digit lookup: {valid, nibble}
  function automatic logic [4:0] hex_lookup(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/data_url_payload_decoder_top.sv
`timescale 1ns / 1ps
// Data URL payload decoder, base64 or percent decoding selected by cfg_decode_mode
// (0 percent, 1 base64). Write it through cfg_valid/cfg_ready, which is always ready,
// only while the block is idle.
// Input queue side: drive in_char/in_last with in_push; a transaction is taken at a
// clock edge with in_push high and in_full low. in_last marks the final character.
// Result queue side: while out_empty is low the oldest result sits on out_byte,
// out_has_byte, out_end_of_payload and out_decode_error; out_pop takes it.
// Results reach the outputs via the packet queue, then the output register.
// Throughput: one character per cycle while each yields at most one result and the
// result side keeps popping; a character that yields two or three results holds the
// back end while they leave one result per cycle from the output register, and a
// four-entry packet queue between front and back absorbs the burst.
// A stalled result side fills the output register, then the packet queue, and
// then in_full rises; nothing is lost or repeated.
// The last character of a payload always yields at least one result, the final one
// carrying out_end_of_payload and the error flag; decoder state then clears.
// Reset (rst_n low, synchronous) empties both queues, clears decoder state and
// selects percent mode.
module data_url_payload_decoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_char,
  input  logic       in_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_end_of_payload,
  output logic       out_decode_error,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_decode_mode
);
  import dup_pkg::*;

  logic mode_r;
  logic accept;
  logic pkt_vld;
  pkt_t pkt;
  pkt_t head;
  logic fifo_full;
  logic fifo_empty;
  logic fifo_push;
  logic fifo_pop;
  logic out_vld;
  res_t res;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_decode_mode;
    end
  end

  assign in_full   = fifo_full;
  assign accept    = in_push && !fifo_full;
  assign fifo_push = accept && pkt_vld;

  // front: classify characters and keep decoder state
  dup_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode_i    (mode_r),
    .accept_i  (accept),
    .char_i    (in_char),
    .last_i    (in_last),
    .pkt_vld_o (pkt_vld),
    .pkt_o     (pkt)
  );

  // packet queue
  dup_pkt_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (fifo_push),
    .push_pkt_i (pkt),
    .pop_i      (fifo_pop),
    .head_o     (head),
    .full_o     (fifo_full),
    .empty_o    (fifo_empty)
  );

  // back: serialize packets into result transactions
  dup_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_i     (head),
    .head_vld_i (!fifo_empty),
    .head_pop_o (fifo_pop),
    .out_pop_i  (out_pop),
    .out_vld_o  (out_vld),
    .res_o      (res)
  );

  assign out_empty          = !out_vld;
  assign out_byte           = res.data;
  assign out_has_byte       = res.has_byte;
  assign out_end_of_payload = res.eop;
  assign out_decode_error   = res.err;

`include "data_url_payload_decoder_top_assert.svh"

  `DUP_ASSERT_NOW(a_nobyte_is_end, !out_empty && !out_has_byte, out_end_of_payload, "empty result not at end of payload")
  `DUP_ASSERT_NOW(a_err_only_end, !out_empty && out_decode_error, out_end_of_payload, "error flag on a non-final result")
  `DUP_ASSERT_NOW(a_pop_nonempty, fifo_pop, !fifo_empty, "packet queue popped while empty")
  `DUP_ASSERT_NEXT(a_full_then_no_push, fifo_full && !fifo_pop, !fifo_empty, "full packet queue lost its contents")

endmodule

FILE: hw/rtl/dup_front.sv
`timescale 1ns / 1ps

module dup_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          mode_i,
  input  logic          accept_i,
  input  logic [7:0]    char_i,
  input  logic          last_i,
  output logic          pkt_vld_o,
  output dup_pkg::pkt_t pkt_o
);
  import dup_pkg::*;

  localparam logic [1:0] StgIdle = 2'd0;
  localparam logic [1:0] StgPct  = 2'd1;
  localparam logic [1:0] StgHex  = 2'd2;

  logic [5:0] res_r, res_nxt;
  logic [2:0] bc_r, bc_nxt;
  logic       pad_r, pad_nxt;
  logic       err_r, err_nxt;
  logic [1:0] stage_r, stage_nxt;
  logic [7:0] held_r, held_nxt;

  logic [PktSlots-1:0][7:0] slot;
  logic [1:0]               pn;

  // classify the character and build its packet
  always_comb begin
    logic [6:0]  b64l;
    logic [4:0]  hc;
    logic [4:0]  hh;
    logic [11:0] b64_buf;
    logic [3:0]  b64_cnt;
    logic        ws;
    b64l      = b64_lookup(char_i);
    hc        = hex_lookup(char_i);
    hh        = hex_lookup(held_r);
    ws        = (char_i == CharSpace) || (char_i == CharTab) ||
                (char_i == CharCr) || (char_i == CharLf);
    b64_buf   = {res_r, b64l[5:0]};
    b64_cnt   = {1'b0, bc_r} + 4'd6;
    res_nxt   = res_r;
    bc_nxt    = bc_r;
    pad_nxt   = pad_r;
    err_nxt   = err_r;
    stage_nxt = stage_r;
    held_nxt  = held_r;
    slot      = '0;
    pn        = 2'd0;

    if (mode_i) begin
      // base64 path
      if (!(pad_r || err_r)) begin
        if (char_i == CharEq) begin
          pad_nxt = 1'b1;
        end else if (!b64l[6]) begin
          if (!ws) begin
            err_nxt = 1'b1;
          end
        end else begin
          if (b64_cnt >= 4'd8) begin
            b64_cnt  = b64_cnt - 4'd8;
            slot[pn] = 8'(b64_buf >> b64_cnt);
            pn       = pn + 2'd1;
          end
          res_nxt = 6'(b64_buf & ((12'd1 << b64_cnt) - 12'd1));
          bc_nxt  = b64_cnt[2:0];
        end
      end
    end else begin
      // percent path
      unique case (stage_r)
        StgPct: begin
          if (hc[4]) begin
            held_nxt  = char_i;
            stage_nxt = StgHex;
          end else begin
            slot[pn] = CharPct;
            pn       = pn + 2'd1;
            if (char_i == CharPct) begin
              stage_nxt = StgPct;
            end else begin
              stage_nxt = StgIdle;
              slot[pn]  = char_i;
              pn        = pn + 2'd1;
            end
          end
        end
        StgHex: begin
          if (hc[4] && hh[4]) begin
            slot[pn]  = {hh[3:0], hc[3:0]};
            pn        = pn + 2'd1;
            stage_nxt = StgIdle;
          end else begin
            slot[pn] = CharPct;
            pn       = pn + 2'd1;
            slot[pn] = held_r;
            pn       = pn + 2'd1;
            if (char_i == CharPct) begin
              stage_nxt = StgPct;
            end else begin
              stage_nxt = StgIdle;
              slot[pn]  = char_i;
              pn        = pn + 2'd1;
            end
          end
        end
        default: begin
          if (char_i == CharPct) begin
            stage_nxt = StgPct;
          end else begin
            stage_nxt = StgIdle;
            slot[pn]  = char_i;
            pn        = pn + 2'd1;
          end
        end
      endcase
    end

    pkt_o.err = 1'b0;
    // end of payload: flush held percent characters, then clear
    if (last_i) begin
      if (!mode_i) begin
        if (stage_nxt == StgPct) begin
          slot[pn] = CharPct;
          pn       = pn + 2'd1;
        end else if (stage_nxt == StgHex) begin
          slot[pn] = CharPct;
          pn       = pn + 2'd1;
          slot[pn] = held_nxt;
          pn       = pn + 2'd1;
        end
      end
      pkt_o.err = err_nxt;
      res_nxt   = '0;
      bc_nxt    = '0;
      pad_nxt   = 1'b0;
      err_nxt   = 1'b0;
      stage_nxt = StgIdle;
      held_nxt  = '0;
    end

    pkt_o.bytes   = slot;
    pkt_o.no_byte = (pn == 2'd0);
    pkt_o.cnt     = (pn == 2'd0) ? 2'd1 : pn;
    pkt_o.last    = last_i;
    pkt_vld_o     = (pn != 2'd0) || last_i;
  end

  // decoder state, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r   <= '0;
      bc_r    <= '0;
      pad_r   <= 1'b0;
      err_r   <= 1'b0;
      stage_r <= StgIdle;
      held_r  <= '0;
    end else if (accept_i) begin
      res_r   <= res_nxt;
      bc_r    <= bc_nxt;
      pad_r   <= pad_nxt;
      err_r   <= err_nxt;
      stage_r <= stage_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

FILE: hw/rtl/dup_pkt_fifo.sv
`timescale 1ns / 1ps

module dup_pkt_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  dup_pkg::pkt_t push_pkt_i,
  input  logic          pop_i,
  output dup_pkg::pkt_t head_o,
  output logic          full_o,
  output logic          empty_o
);
  import dup_pkg::*;

  pkt_t               mem_r [PktDepth];
  logic [PktPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PktPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PktPtrW:0]   cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == (PktPtrW+1)'(PktDepth));
  assign empty_o = (cnt_r == '0);
  assign head_o  = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_i ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (PktPtrW+1)'(push_i) - (PktPtrW+1)'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // packet storage
  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_pkt_i;
    end
  end

endmodule

FILE: hw/rtl/dup_back.sv
`timescale 1ns / 1ps

module dup_back (
  input  logic          clk,
  input  logic          rst_n,
  input  dup_pkg::pkt_t head_i,
  input  logic          head_vld_i,
  output logic          head_pop_o,
  input  logic          out_pop_i,
  output logic          out_vld_o,
  output dup_pkg::res_t res_o
);
  import dup_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       vld_r, vld_nxt;
  res_t       res_r, res_nxt;
  logic       load;
  logic       take;
  logic       tail;

  assign out_vld_o = vld_r;
  assign res_o     = res_r;

  // walk the head packet one result per cycle into the output register while it is free or popped
  always_comb begin
    load       = !vld_r || out_pop_i;
    take       = load && head_vld_i;
    tail       = (idx_r == head_i.cnt - 2'd1);
    head_pop_o = take && tail;
    idx_nxt    = idx_r;
    res_nxt    = res_r;
    vld_nxt    = vld_r && !out_pop_i;
    if (take) begin
      idx_nxt          = tail ? 2'd0 : idx_r + 2'd1;
      vld_nxt          = 1'b1;
      res_nxt.data     = head_i.bytes[idx_r];
      res_nxt.has_byte = !head_i.no_byte;
      res_nxt.eop      = tail && head_i.last;
      res_nxt.err      = tail && head_i.err;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
